// ===== sv/h264fua_pkg.sv =====
// Shared types and constants for the H.264 RTP FU-A packetizer.
`default_nettype none
package h264fua_pkg;

	// Field widths
	localparam int DATA_W     = 8;
	localparam int UNIT_LEN_W = 24;
	localparam int ELAPSED_W  = 24;
	localparam int MTU_W      = 14;
	localparam int PT_W       = 7;
	localparam int SSRC_W     = 32;
	localparam int SEQ_W      = 16;
	localparam int TS_W       = 32;
	localparam int REG_IDX_W  = 2;

	// Configuration reset values
	localparam logic [MTU_W-1:0]  MTU_RESET  = 14'd1400;
	localparam logic [PT_W-1:0]   PT_RESET   = 7'd96;
	localparam logic [SSRC_W-1:0] SSRC_RESET = 32'd10;

	// Packet format
	localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
	localparam logic [7:0] NAL_NRI_MASK     = 8'h60;
	localparam logic [4:0] FU_A_TYPE        = 5'd28;
	localparam logic [4:0] NAL_ACCESS_LIMIT = 5'd6;
	localparam int         RTP_HDR_BYTES    = 12;
	localparam int         FU_HDR_BYTES     = 2;
	localparam int         START_CODE_BYTES = 4;
	localparam int         SHORT_UNIT_BYTES = 5;
	localparam int         MTU_FRAG_FLOOR   = 15;

	// Timestamp: elapsed_us * 9 / 100, the /100 as a reciprocal multiply
	localparam int             TS_X_W     = 28;
	localparam int             TS_RECIP_W = 29;
	localparam logic [TS_RECIP_W-1:0] TS_RECIP = 29'd343597384;
	localparam int             TS_SHIFT   = 35;
	localparam int             TS_PROD_W  = TS_X_W + TS_RECIP_W;

	// Command queue between front and back
	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_PTR_W = 2;
	localparam int CMDQ_CNT_W = 3;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_MAX_PACKET   = 2'd0,
		REG_PAYLOAD_TYPE = 2'd1,
		REG_STREAM_SRC   = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [MTU_W-1:0]  max_packet_bytes;
		logic [PT_W-1:0]   payload_type;
		logic [SSRC_W-1:0] stream_source_id;
	} cfg_t;

	// One classified input byte: which output bytes it causes
	typedef struct packed {
		logic              short_flag;
		logic              hdr;
		logic              marker;
		logic [SEQ_W-1:0]  seq;
		logic [TS_W-1:0]   ts;
		logic              fu;
		logic [7:0]        fu_ind;
		logic [7:0]        fu_hdr;
		logic              data;
		logic [DATA_W-1:0] data_byte;
		logic              data_end;
	} cmd_t;

	function automatic logic is_access(input logic [7:0] nal);
		logic [4:0] t;
		t = nal[4:0];
		return (t != 5'd0) && (t < NAL_ACCESS_LIMIT);
	endfunction

endpackage
`default_nettype wire

// ===== sv/h264fua_cfg.sv =====
// Configuration registers of the packetizer.
`default_nettype none
module h264fua_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 wr_valid,
	input  wire logic [h264fua_pkg::REG_IDX_W-1:0]    wr_index,
	input  wire logic [h264fua_pkg::SSRC_W-1:0]       wr_data,
	output h264fua_pkg::cfg_t                         cfg
);
	import h264fua_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_packet_bytes <= MTU_RESET;
			cfg_q.payload_type     <= PT_RESET;
			cfg_q.stream_source_id <= SSRC_RESET;
		end else if (wr_valid) begin
			case (reg_idx_t'(wr_index))
				REG_MAX_PACKET:   cfg_q.max_packet_bytes <= wr_data[MTU_W-1:0];
				REG_PAYLOAD_TYPE: cfg_q.payload_type     <= wr_data[PT_W-1:0];
				REG_STREAM_SRC:   cfg_q.stream_source_id <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

// ===== sv/h264fua_front.sv =====
// Front end: tracks unit position and fragments, classifies each byte into a command.
`default_nettype none
module h264fua_front #(
	parameter int LENGTH_BITS = 24
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  in_valid,
	output logic                                       in_ready,
	input  wire logic [h264fua_pkg::DATA_W-1:0]        data_byte,
	input  wire logic                                  unit_first,
	input  wire logic [h264fua_pkg::UNIT_LEN_W-1:0]    unit_length,
	input  wire logic                                  unit_end,
	input  wire logic [h264fua_pkg::ELAPSED_W-1:0]     elapsed_us,
	input  wire h264fua_pkg::cfg_t                     cfg,
	input  wire logic                                  q_full,
	output logic                                       push,
	output h264fua_pkg::cmd_t                          cmd
);
	import h264fua_pkg::*;

	localparam int CMP_W = ((LENGTH_BITS > MTU_W) ? LENGTH_BITS : MTU_W) + 1;

	logic [LENGTH_BITS-1:0] total_q, pos_q;
	logic [MTU_W-1:0]       frag_left_q;
	logic                   frag_mode_q, first_frag_q;
	logic [7:0]             nal_q;
	logic [SEQ_W-1:0]       seq_q;
	logic [TS_W-1:0]        rtp_time_q;

	logic                   ts_v_s1, ts_v_s2;
	logic [TS_X_W-1:0]      ts_x_s1;
	logic [TS_PROD_W-1:0]   ts_prod_s2;

	logic                   accept;
	logic [LENGTH_BITS-1:0] len_in;

	// next-state values
	logic [LENGTH_BITS-1:0] tl, pos, pos_nx;
	logic [MTU_W-1:0]       fl, fl_nx, size_base, size;
	logic                   fm, ff, ff_nx, in_range, last, close, frag_e, store_nal;
	logic [LENGTH_BITS-1:0] remaining;
	cmd_t                   c;

	assign accept = in_valid && in_ready;
	assign in_ready = !q_full;
	assign len_in = LENGTH_BITS'(unit_length);

	always_comb begin
		tl = unit_first ? len_in : total_q;
		pos = unit_first ? '0 : pos_q;
		fl = unit_first ? '0 : frag_left_q;
		ff = unit_first ? 1'b1 : first_frag_q;
		fm = unit_first ? ((CMP_W'(len_in) + CMP_W'(RTP_HDR_BYTES))
				>= CMP_W'(cfg.max_packet_bytes)) : frag_mode_q;

		in_range = pos < tl;
		last = pos == (tl - LENGTH_BITS'(1));
		remaining = tl - pos;
		size_base = (cfg.max_packet_bytes > MTU_W'(MTU_FRAG_FLOOR))
			? (cfg.max_packet_bytes - MTU_W'(RTP_HDR_BYTES + FU_HDR_BYTES)) : MTU_W'(1);
		frag_e = CMP_W'(remaining) <= CMP_W'(size_base);
		size = frag_e ? MTU_W'(remaining) : size_base;

		c = '0;
		c.short_flag = unit_first && (len_in < LENGTH_BITS'(SHORT_UNIT_BYTES));
		c.seq = seq_q;
		c.ts = rtp_time_q;
		c.data_byte = data_byte;
		c.fu_ind = (nal_q & NAL_NRI_MASK) | 8'(FU_A_TYPE);
		c.fu_hdr = {ff, frag_e, 1'b0, nal_q[4:0]};
		close = 1'b0;
		store_nal = 1'b0;
		fl_nx = fl;
		ff_nx = ff;

		if (in_range) begin
			if (pos == LENGTH_BITS'(START_CODE_BYTES)) begin
				if (!fm) begin
					c.hdr = 1'b1;
					c.marker = is_access(data_byte);
					c.data = 1'b1;
					close = last;
				end else begin
					store_nal = 1'b1;
				end
			end else if (pos > LENGTH_BITS'(START_CODE_BYTES)) begin
				c.data = 1'b1;
				if (!fm) begin
					close = last;
				end else begin
					if (fl == '0) begin
						// open a new fragment
						c.hdr = 1'b1;
						c.fu = 1'b1;
						c.marker = frag_e && is_access(nal_q);
						fl_nx = size - MTU_W'(1);
						ff_nx = 1'b0;
					end else begin
						fl_nx = fl - MTU_W'(1);
					end
					close = fl_nx == '0;
				end
			end
		end
		c.data_end = c.data && (close || unit_end);

		pos_nx = in_range ? (pos + LENGTH_BITS'(1)) : pos;
		if (unit_end) begin
			pos_nx = tl;
			fl_nx = '0;
		end
	end

	assign push = accept && (c.short_flag || c.hdr || c.data);
	assign cmd = c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q      <= '0;
			pos_q        <= '0;
			frag_left_q  <= '0;
			frag_mode_q  <= 1'b0;
			first_frag_q <= 1'b1;
			nal_q        <= '0;
			seq_q        <= '0;
		end else if (accept) begin
			total_q      <= tl;
			pos_q        <= pos_nx;
			frag_left_q  <= fl_nx;
			frag_mode_q  <= fm;
			first_frag_q <= ff_nx;
			if (store_nal) begin
				nal_q <= data_byte;
			end
			if (c.hdr) begin
				seq_q <= seq_q + SEQ_W'(1);
			end
		end
	end

	// Timestamp advance: x = el*9, then x/100 by reciprocal, then accumulate.
	// The next header is at least four accepted bytes away, so the lag through the s1 and s2 registers is hidden.
	always_ff @(posedge clk) begin
		ts_x_s1    <= (TS_X_W'(elapsed_us) << 3) + TS_X_W'(elapsed_us);
		ts_prod_s2 <= TS_PROD_W'(ts_x_s1) * TS_PROD_W'(TS_RECIP);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ts_v_s1    <= 1'b0;
			ts_v_s2    <= 1'b0;
			rtp_time_q <= '0;
		end else begin
			ts_v_s1 <= accept && unit_end;
			ts_v_s2 <= ts_v_s1;
			if (ts_v_s2) begin
				rtp_time_q <= rtp_time_q + TS_W'(ts_prod_s2 >> TS_SHIFT);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/h264fua_cmdq.sv =====
// Short command queue between the front end and the byte sequencer.
`default_nettype none
module h264fua_cmdq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire h264fua_pkg::cmd_t wr_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 valid,
	output h264fua_pkg::cmd_t    rd_cmd
);
	import h264fua_pkg::*;

	cmd_t                  mem_q [CMDQ_DEPTH];
	logic [CMDQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CMDQ_CNT_W-1:0] cnt_q;

	assign full = cnt_q == CMDQ_CNT_W'(CMDQ_DEPTH);
	assign valid = cnt_q != '0;
	assign rd_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + CMDQ_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + CMDQ_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + CMDQ_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CMDQ_CNT_W'(1);
				default: ;
			endcase
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("command pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> valid) else $error("command popped from empty queue");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CMDQ_CNT_W'(CMDQ_DEPTH)) else $error("queue fill count overflow");

endmodule
`default_nettype wire

// ===== sv/h264fua_back.sv =====
// Back end: walks each command's byte slots and drives the output register.
`default_nettype none
module h264fua_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire h264fua_pkg::cfg_t                    cfg,
	input  wire logic                                 q_valid,
	input  wire h264fua_pkg::cmd_t                    q_cmd,
	output logic                                      q_pop,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [h264fua_pkg::DATA_W-1:0]            out_byte,
	output logic                                      out_end,
	output logic                                      out_run_last,
	output logic                                      out_short
);
	import h264fua_pkg::*;

	localparam int SLOT_W = 4;
	localparam int NSLOTS = 16;
	localparam logic [SLOT_W-1:0] SLOT_SHORT   = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_VER     = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_PT      = 4'd2;
	localparam logic [SLOT_W-1:0] SLOT_SEQ_HI  = 4'd3;
	localparam logic [SLOT_W-1:0] SLOT_SEQ_LO  = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_TS3     = 4'd5;
	localparam logic [SLOT_W-1:0] SLOT_TS2     = 4'd6;
	localparam logic [SLOT_W-1:0] SLOT_TS1     = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_TS0     = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_SSRC3   = 4'd9;
	localparam logic [SLOT_W-1:0] SLOT_SSRC2   = 4'd10;
	localparam logic [SLOT_W-1:0] SLOT_SSRC1   = 4'd11;
	localparam logic [SLOT_W-1:0] SLOT_SSRC0   = 4'd12;
	localparam logic [SLOT_W-1:0] SLOT_FU_IND  = 4'd13;
	localparam logic [SLOT_W-1:0] SLOT_FU_HDR  = 4'd14;
	localparam logic [SLOT_W-1:0] SLOT_DATA    = 4'd15;

	typedef struct packed {
		logic              found;
		logic [SLOT_W-1:0] slot;
	} slot_pick_t;

	function automatic logic slot_on(input logic [SLOT_W-1:0] s, input cmd_t c);
		logic on;
		case (s) inside
			SLOT_SHORT:              on = c.short_flag;
			[SLOT_VER:SLOT_SSRC0]:   on = c.hdr;
			SLOT_FU_IND, SLOT_FU_HDR: on = c.fu;
			SLOT_DATA:               on = c.data;
			default:                 on = 1'b0;
		endcase
		return on;
	endfunction

	// lowest active slot at or above start
	function automatic slot_pick_t first_on(input logic [SLOT_W:0] start, input cmd_t c);
		slot_pick_t r;
		r = '0;
		for (int i = NSLOTS - 1; i >= 0; i--) begin
			if ((SLOT_W+1)'(i) >= start && slot_on(SLOT_W'(i), c)) begin
				r.found = 1'b1;
				r.slot = SLOT_W'(i);
			end
		end
		return r;
	endfunction

	cmd_t              cur_q;
	logic              busy_q;
	logic [SLOT_W-1:0] slot_q;

	logic              out_valid_q, out_end_q, out_run_last_q, out_short_q;
	logic [DATA_W-1:0] out_byte_q;

	logic              advance, cur_on;
	slot_pick_t        nxt, first;
	logic [7:0]        emit_byte;

	assign advance = !out_valid_q || out_ready;
	assign nxt = first_on((SLOT_W+1)'(slot_q) + (SLOT_W+1)'(1), cur_q);
	assign first = first_on('0, q_cmd);
	assign cur_on = slot_on(slot_q, cur_q);
	// load the next command when idle or when the current one emits its last byte
	assign q_pop = advance && q_valid && (!busy_q || !nxt.found);

	always_comb begin
		case (slot_q)
			SLOT_SHORT:  emit_byte = 8'd0;
			SLOT_VER:    emit_byte = RTP_VERSION_BYTE;
			SLOT_PT:     emit_byte = {cur_q.marker, cfg.payload_type};
			SLOT_SEQ_HI: emit_byte = cur_q.seq[15:8];
			SLOT_SEQ_LO: emit_byte = cur_q.seq[7:0];
			SLOT_TS3:    emit_byte = cur_q.ts[31:24];
			SLOT_TS2:    emit_byte = cur_q.ts[23:16];
			SLOT_TS1:    emit_byte = cur_q.ts[15:8];
			SLOT_TS0:    emit_byte = cur_q.ts[7:0];
			SLOT_SSRC3:  emit_byte = cfg.stream_source_id[31:24];
			SLOT_SSRC2:  emit_byte = cfg.stream_source_id[23:16];
			SLOT_SSRC1:  emit_byte = cfg.stream_source_id[15:8];
			SLOT_SSRC0:  emit_byte = cfg.stream_source_id[7:0];
			SLOT_FU_IND: emit_byte = cur_q.fu_ind;
			SLOT_FU_HDR: emit_byte = cur_q.fu_hdr;
			SLOT_DATA:   emit_byte = cur_q.data_byte;
			default:     emit_byte = 8'd0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_cmd;
		end
		if (advance && busy_q) begin
			out_byte_q     <= emit_byte;
			out_end_q      <= (slot_q == SLOT_DATA) && cur_q.data_end;
			out_run_last_q <= !nxt.found;
			out_short_q    <= slot_q == SLOT_SHORT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= SLOT_SHORT;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= busy_q;
			if (busy_q && nxt.found) begin
				slot_q <= nxt.slot;
			end else if (q_pop) begin
				busy_q <= 1'b1;
				slot_q <= first.slot;
			end else begin
				busy_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign out_end      = out_end_q;
	assign out_run_last = out_run_last_q;
	assign out_short    = out_short_q;

	a_slot_active: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cur_on) else $error("sequencer parked on an inactive slot");
	a_short_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_short_q) |-> (out_run_last_q && !out_end_q))
		else $error("short-unit flag not a lone result");
	a_pop_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!busy_q || !nxt.found)) else $error("command loaded mid-expansion");

endmodule
`default_nettype wire

// ===== sv/h264_rtp_fua_packetizer_core.sv =====
// Top level of the H.264 RTP packetizer: single NAL packets and FU-A fragments.
`default_nettype none
// Takes an H.264 unit one byte per cycle (start code included, length on the
// first byte) and emits RTP packets as a byte stream, 12-byte header first,
// plus FU indicator and FU header on each fragment. The front end accepts one
// input byte per cycle whenever its 4-entry command queue has room; the back
// end sequencer emits one output byte per cycle while m_axis_tready is high
// and commands remain, so it sets the input rate: a payload byte yields one
// byte, the opener of a single packet adds the 12-byte header, the opener of
// a fragment adds header, FU indicator and FU header; a short-unit flag is one.
// Bytes that produce nothing push no command. The unit's last byte starts the
// timestamp advance through ts_v_s1 and ts_v_s2. After reset it is ready at once.
module h264_rtp_fua_packetizer_core #(
	parameter int LENGTH_BITS = 24
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// stream in
	input  wire logic                                   s_axis_tvalid,
	output logic                                        s_axis_tready,
	input  wire logic [55:0]                            s_axis_tdata,  // data_byte, unit_length, elapsed_us
	input  wire logic                                   s_axis_tlast,  // unit_end
	input  wire logic                                   s_axis_tuser,  // unit_first
	// stream out
	output logic                                        m_axis_tvalid,
	input  wire logic                                   m_axis_tready,
	output logic [h264fua_pkg::DATA_W-1:0]              m_axis_tdata,  // packet_byte
	output logic                                        m_axis_tlast,  // packet_end
	output logic [1:0]                                  m_axis_tuser,  // run_last, short_unit
	// configuration writes
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [h264fua_pkg::REG_IDX_W-1:0]      cfg_index,
	input  wire logic [h264fua_pkg::SSRC_W-1:0]         cfg_data
);
	import h264fua_pkg::*;

	cfg_t cfg;
	cmd_t push_cmd, pop_cmd;
	logic push, q_full, q_pop, q_valid;
	logic run_last, short_unit;

	assign cfg_ready = 1'b1;

	h264fua_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	h264fua_front #(
		.LENGTH_BITS (LENGTH_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_ready    (s_axis_tready),
		.data_byte   (s_axis_tdata[7:0]),
		.unit_first  (s_axis_tuser),
		.unit_length (s_axis_tdata[31:8]),
		.unit_end    (s_axis_tlast),
		.elapsed_us  (s_axis_tdata[55:32]),
		.cfg         (cfg),
		.q_full      (q_full),
		.push        (push),
		.cmd         (push_cmd)
	);

	h264fua_cmdq u_cmdq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (push_cmd),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rd_cmd (pop_cmd)
	);

	h264fua_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.q_valid      (q_valid),
		.q_cmd        (pop_cmd),
		.q_pop        (q_pop),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.out_byte     (m_axis_tdata),
		.out_end      (m_axis_tlast),
		.out_run_last (run_last),
		.out_short    (short_unit)
	);

	assign m_axis_tuser = {short_unit, run_last};

endmodule
`default_nettype wire
